// ===== hdl/dpt_pkg.sv =====
package dpt_pkg;

    // Sizes of the address space and the frame pool (powers of two)
    localparam int NUM_PAGES   = 256;
    localparam int NUM_FRAMES  = 256;
    localparam int OFFSET_BITS = 8;

    localparam int ADDR_W      = 16;
    localparam int PAGE_W      = 8;
    localparam int FRAME_W     = 8;
    localparam int PAGE_BITS   = $clog2(NUM_PAGES);
    localparam int FRAME_BITS  = $clog2(NUM_FRAMES);
    localparam int COUNT_W     = FRAME_BITS + 1;

    localparam int LFSR_W      = 16;
    localparam logic [LFSR_W-1:0] SEED_RESET = 16'd44257;
    localparam logic [LFSR_W-1:0] LFSR_MASK  = 16'hB400;

    localparam int OUT_FIELDS_W = PAGE_W + FRAME_W + ADDR_W + 1 + 1 + PAGE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Controller to datapath commands
    typedef struct packed {
        logic sel_in_addr;    // table read address from the input port
        logic accept;         // capture the incoming address
        logic finish_hit;     // give the result of a table hit
        logic finish_free;    // map the page to the next unused frame
        logic step_lfsr;      // advance the victim generator, read the owner
        logic finish_victim;  // evict the owner and map the page to the victim
    } dpt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hit;            // page of the held address is mapped
        logic full;           // every frame is in use
    } dpt_sts_t;

endpackage

// ===== hdl/dpt_ram.sv =====
module dpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dpt_ctrl.sv =====
module dpt_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  dpt_pkg::dpt_sts_t sts,
    output dpt_pkg::dpt_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOOK = 3'b010,
        S_VICT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;
    logic   finish;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign finish   = cmd.finish_hit || cmd.finish_free || cmd.finish_victim;

    // Sequence one lookup: read, then commit or fetch the victim owner
    always_comb
    begin
        state_next        = state_reg;
        cmd               = '0;
        cmd.sel_in_addr   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (sts.hit)
                begin
                    if (out_free)
                    begin
                        cmd.finish_hit = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (!sts.full)
                begin
                    if (out_free)
                    begin
                        cmd.finish_free = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step_lfsr = 1'b1;
                    state_next    = S_VICT;
                end
            end
            S_VICT:
            begin
                if (out_free)
                begin
                    cmd.finish_victim = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer completes
    always_comb
    begin
        if (finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.finish_hit, cmd.finish_free, cmd.step_lfsr,
                  cmd.finish_victim}))
        else $error("more than one controller action in a cycle");

    a_step_to_vict: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_lfsr |=> (state_reg == S_VICT))
        else $error("victim step not followed by the eviction state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !finish)
        else $error("result written while the previous one is still waiting");

endmodule

// ===== hdl/dpt_dp.sv =====
module dpt_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [dpt_pkg::ADDR_W-1:0]      in_addr,
    input  logic                            cfg_valid,
    input  logic [dpt_pkg::LFSR_W-1:0]      cfg_data,
    input  dpt_pkg::dpt_cmd_t               cmd,
    output dpt_pkg::dpt_sts_t               sts,
    output logic [dpt_pkg::OUT_TDATA_W-1:0] out_data
);

    localparam int PB = dpt_pkg::PAGE_BITS;
    localparam int FB = dpt_pkg::FRAME_BITS;

    logic [dpt_pkg::ADDR_W-1:0]   addr_reg;
    logic [dpt_pkg::NUM_PAGES-1:0] valid_reg, valid_next;
    logic [dpt_pkg::COUNT_W-1:0]  used_reg, used_next;
    logic [dpt_pkg::LFSR_W-1:0]   lfsr_reg, lfsr_next, lfsr_step;
    logic [FB-1:0]                victim_reg, victim_next;

    logic [dpt_pkg::PAGE_W-1:0]   page_num;
    logic [dpt_pkg::PAGE_W-1:0]   in_page;
    logic [PB-1:0]                idx, pf_raddr;
    logic [FB-1:0]                pf_rdata, fo_raddr, new_frame;
    logic [PB-1:0]                fo_rdata;
    logic [dpt_pkg::OFFSET_BITS-1:0] offset;
    logic                         commit, ev_valid;

    logic [dpt_pkg::PAGE_W-1:0]   o_page_reg, o_frame_reg, o_evpage_reg;
    logic [dpt_pkg::ADDR_W-1:0]   o_phys_reg;
    logic                         o_fault_reg, o_evvalid_reg;
    logic [dpt_pkg::PAGE_W-1:0]   o_frame_next, o_evpage_next;
    logic [dpt_pkg::ADDR_W-1:0]   o_phys_next;

    // Split the address into page and offset
    assign in_page  = dpt_pkg::PAGE_W'(in_addr >> dpt_pkg::OFFSET_BITS);
    assign page_num = dpt_pkg::PAGE_W'(addr_reg >> dpt_pkg::OFFSET_BITS);
    assign idx      = page_num[PB-1:0];
    assign offset   = addr_reg[dpt_pkg::OFFSET_BITS-1:0];
    assign pf_raddr = cmd.sel_in_addr ? in_page[PB-1:0] : idx;

    // Galois step, shifting right
    assign lfsr_step = {1'b0, lfsr_reg[dpt_pkg::LFSR_W-1:1]}
                       ^ (lfsr_reg[0] ? dpt_pkg::LFSR_MASK : '0);
    assign fo_raddr  = cmd.step_lfsr ? lfsr_step[FB-1:0] : victim_reg;

    assign sts.hit  = valid_reg[idx];
    assign sts.full = (used_reg == dpt_pkg::COUNT_W'(dpt_pkg::NUM_FRAMES));

    assign commit    = cmd.finish_free || cmd.finish_victim;
    assign new_frame = cmd.finish_victim ? victim_reg : used_reg[FB-1:0];
    assign ev_valid  = cmd.finish_victim && valid_reg[fo_rdata];

    // Page table: page to frame
    dpt_ram #(
        .WIDTH (FB),
        .DEPTH (dpt_pkg::NUM_PAGES)
    ) u_page_frame (
        .clk   (clk),
        .we    (commit),
        .waddr (idx),
        .wdata (new_frame),
        .raddr (pf_raddr),
        .rdata (pf_rdata)
    );

    // Reverse map: frame to owning page
    dpt_ram #(
        .WIDTH (PB),
        .DEPTH (dpt_pkg::NUM_FRAMES)
    ) u_frame_owner (
        .clk   (clk),
        .we    (commit),
        .waddr (new_frame),
        .wdata (idx),
        .raddr (fo_raddr),
        .rdata (fo_rdata)
    );

    // Update valid bits, frame count and victim generator
    always_comb
    begin
        valid_next  = valid_reg;
        used_next   = used_reg;
        lfsr_next   = lfsr_reg;
        victim_next = victim_reg;
        if (ev_valid)
        begin
            valid_next[fo_rdata] = 1'b0;
        end
        if (commit)
        begin
            valid_next[idx] = 1'b1;
        end
        if (cmd.finish_free)
        begin
            used_next = used_reg + dpt_pkg::COUNT_W'(1);
        end
        if (cmd.step_lfsr)
        begin
            lfsr_next   = lfsr_step;
            victim_next = lfsr_step[FB-1:0];
        end
        if (cfg_valid)
        begin
            lfsr_next = (cfg_data == '0) ? dpt_pkg::LFSR_W'(1) : cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
            lfsr_reg  <= dpt_pkg::SEED_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            lfsr_reg  <= lfsr_next;
        end
    end

    // Result fields
    assign o_frame_next  = dpt_pkg::PAGE_W'(cmd.finish_hit ? pf_rdata : new_frame);
    assign o_phys_next   = dpt_pkg::ADDR_W'((32'(o_frame_next) << dpt_pkg::OFFSET_BITS)
                                            | 32'(offset));
    assign o_evpage_next = ev_valid ? dpt_pkg::PAGE_W'(fo_rdata) : '0;

    // Payload registers: input address, victim and result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= in_addr;
        end
        victim_reg <= victim_next;
        if (cmd.finish_hit || commit)
        begin
            o_page_reg    <= page_num;
            o_frame_reg   <= o_frame_next;
            o_phys_reg    <= o_phys_next;
            o_fault_reg   <= commit;
            o_evvalid_reg <= ev_valid;
            o_evpage_reg  <= o_evpage_next;
        end
    end

    assign out_data = dpt_pkg::OUT_TDATA_W'({o_evpage_reg, o_evvalid_reg, o_fault_reg,
                                             o_phys_reg, o_frame_reg, o_page_reg});

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= dpt_pkg::COUNT_W'(dpt_pkg::NUM_FRAMES))
        else $error("frame count beyond the frame pool");

    a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_lfsr |-> (sts.full && !sts.hit))
        else $error("victim chosen while a frame is free or the page is mapped");

    a_commit_maps: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> valid_reg[$past(idx)])
        else $error("faulting page not mapped after commit");

endmodule

// ===== hdl/demand_paging_translator.sv =====
// Result: registered when the lookup state ends on a hit or a fault that takes an
//   unused frame, or when the eviction state ends if a victim frame is evicted.
// An address is taken only while idle, so a new one waits for the registered read
//   of the page table and its write-back for the previous address.
// Reset: all pages unmapped, frame count zero, victim generator at its reset seed.
module demand_paging_translator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dpt_pkg::ADDR_W-1:0]      s_tdata,   // virtual_addr
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // page_number, frame_number, physical_addr, page_fault, evicted_valid,
    // evicted_page, zero fill
    output logic [dpt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dpt_pkg::LFSR_W-1:0]      cfg_data   // victim_seed
);

    dpt_pkg::dpt_cmd_t cmd;
    dpt_pkg::dpt_sts_t sts;

    // Seed writes always complete at once
    assign cfg_ready = 1'b1;

    dpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dpt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_addr   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_tdata)
    );

endmodule

// ===== sim/tb_demand_paging_translator.sv =====
module tb_demand_paging_translator;

    timeunit 1ns;
    timeprecision 1ps;

    import dpt_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 6;

    // Bit positions of the result fields in m_tdata
    localparam int FRAME_LSB = PAGE_W;
    localparam int PHYS_LSB  = FRAME_LSB + FRAME_W;
    localparam int FAULT_BIT = PHYS_LSB + ADDR_W;
    localparam int EVV_BIT   = FAULT_BIT + 1;
    localparam int EVP_LSB   = EVV_BIT + 1;

    typedef struct {
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] frame_number;
        logic [ADDR_W-1:0]  physical_addr;
        logic               page_fault;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
    } translation_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [ADDR_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [LFSR_W-1:0]      cfg_data;

    // Shadow copy of the translator state
    bit                     page_mapped   [NUM_PAGES];
    logic [FRAME_W-1:0]     page_to_frame [NUM_PAGES];
    logic [PAGE_W-1:0]      frame_to_page [NUM_FRAMES];
    int unsigned            frames_used;
    logic [LFSR_W-1:0]      victim_seed_q;
    logic [LFSR_W-1:0]      victim_state;

    translation_t           pending_xlate[$];
    int                     mismatches;
    bit                     stall_on;
    int                     hold_requests;
    int                     hold_served;
    logic [PAGE_W-1:0]      recent_pages[8];
    int                     recent_wr;

    demand_paging_translator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int rand_gap(int min_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return min_len;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Load the victim generator; a zero seed would lock it up
    function automatic void load_victim_seed(logic [LFSR_W-1:0] seed);
        victim_seed_q = seed;
        victim_state  = (seed == '0) ? LFSR_W'(1) : seed;
    endfunction

    // Advance the Galois generator and return the victim frame
    function automatic int unsigned step_victim();
        logic [LFSR_W-1:0] s;
        logic              lsb;
        s   = victim_state;
        lsb = s[0];
        s   = s >> 1;
        if (lsb)
            s = s ^ LFSR_MASK;
        victim_state = s;
        return int'(s) % NUM_FRAMES;
    endfunction

    // Translate one address and update the shadow page table
    function automatic translation_t translate_addr(logic [ADDR_W-1:0] vaddr);
        translation_t      t;
        int unsigned       page;
        int unsigned       offset;
        int unsigned       idx;
        int unsigned       frame;
        int unsigned       owner;
        page   = (int'(vaddr) >> OFFSET_BITS) & 255;
        offset = int'(vaddr) & ((1 << OFFSET_BITS) - 1);
        idx    = page % NUM_PAGES;
        t.page_fault    = 1'b0;
        t.evicted_valid = 1'b0;
        t.evicted_page  = '0;
        if (page_mapped[idx]) begin
            frame = page_to_frame[idx];
        end
        else begin
            t.page_fault = 1'b1;
            if (frames_used < NUM_FRAMES) begin
                frame = frames_used;
                frames_used++;
            end
            else begin
                frame = step_victim();
                owner = frame_to_page[frame] % NUM_PAGES;
                if (page_mapped[owner]) begin
                    page_mapped[owner] = 1'b0;
                    t.evicted_valid    = 1'b1;
                    t.evicted_page     = PAGE_W'(owner);
                end
            end
            frame = frame & 255;
            frame_to_page[frame % NUM_FRAMES] = PAGE_W'(idx);
            page_to_frame[idx] = FRAME_W'(frame);
            page_mapped[idx]   = 1'b1;
        end
        t.page_number   = PAGE_W'(page);
        t.frame_number  = FRAME_W'(frame);
        t.physical_addr = ADDR_W'((frame << OFFSET_BITS) | offset);
        return t;
    endfunction

    // Offer one address after an optional gap; valid stays high afterwards
    task automatic send_addr(logic [ADDR_W-1:0] vaddr, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vaddr;
        do
            @(posedge clk);
        while (!s_tready);
        pending_xlate.push_back(translate_addr(vaddr));
        recent_pages[recent_wr] = vaddr[ADDR_W-1 -: PAGE_W];
        recent_wr = (recent_wr + 1) % 8;
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_xlate.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(logic [LFSR_W-1:0] seed);
        cfg_valid <= 1'b1;
        cfg_data  <= seed;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        load_victim_seed(seed);
        @(posedge clk);
    endtask

    // Corner addresses, back-to-back hits on one page
    task automatic test_corner_addrs();
        send_addr(16'h0000, 0);
        send_addr(16'hFFFF, 0);
        send_addr(16'hFF00, 0);
        send_addr(16'h00FF, 0);
        send_addr(16'h8001, 1);
        send_addr(16'h8080, 0);
        send_addr(16'h80FE, 0);
        send_addr(16'h7F7F, 2);
        send_addr(16'h0100, 0);
        send_addr(16'hAAAA, 0);
        send_addr(16'h5555, 0);
        send_addr(16'h5555, 0);
        send_addr(16'h55AA, 5);
        send_addr(16'h0001, 0);
        wait_drained();
    endtask

    // Seed writes at the extremes, zero seed, a random one and the reset seed
    task automatic test_seed_writes();
        logic [LFSR_W-1:0] seeds[5];
        seeds[0] = 16'h0001;
        seeds[1] = 16'hFFFF;
        seeds[2] = 16'h0000;
        seeds[3] = LFSR_W'($urandom_range(1, 65535));
        seeds[4] = SEED_RESET;
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            repeat (4)
                send_addr(ADDR_W'($urandom), rand_gap(0));
            wait_drained();
        end
    endtask

    // Mix of recently used pages and fresh ones with random offsets
    task automatic test_random_traffic(int n_items);
        logic [PAGE_W-1:0]   page;
        logic [ADDR_W-1:0]   vaddr;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 45)
                page = recent_pages[$urandom_range(0, 7)];
            else
                page = PAGE_W'($urandom_range(0, 255));
            vaddr = {page, 8'($urandom)};
            send_addr(vaddr, rand_gap(0));
            // Occasional burst on the same page
            if ($urandom_range(0, 9) == 0)
                send_addr({page, 8'($urandom)}, 0);
        end
    endtask

    // Receiver holds off while the sender keeps offering
    task automatic test_output_stall();
        wait_drained();
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_addr(ADDR_W'($urandom), 0);
        wait_drained();
    endtask

    // Full rate on both sides
    task automatic test_full_rate();
        stall_on = 1'b0;
        for (int i = 0; i < 100; i++)
            send_addr(ADDR_W'($urandom), 0);
        wait_drained();
        stall_on = 1'b1;
    endtask

    // Touch every page in shuffled order so every frame gets used
    task automatic test_fill_all_frames();
        logic [PAGE_W-1:0] order[NUM_PAGES];
        logic [PAGE_W-1:0] tmp;
        int                j;
        for (int i = 0; i < NUM_PAGES; i++)
            order[i] = PAGE_W'(i);
        for (int i = NUM_PAGES - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NUM_PAGES; i++)
            send_addr({order[i], 8'($urandom)}, rand_gap(0));
        wait_drained();
    endtask

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_requests != hold_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            else if (stall_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat (rand_gap(1)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare each result transfer with the oldest expected translation
    always @(posedge clk)
    begin
        translation_t t;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_xlate.size() == 0) begin
                $display("%t: unexpected result, tdata=%h", $realtime, m_tdata);
                mismatches++;
            end
            else begin
                t = pending_xlate.pop_front();
                if (m_tdata[PAGE_W-1:0] !== t.page_number) begin
                    $display("%t: page_number expected %h actual %h", $realtime,
                             t.page_number, m_tdata[PAGE_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[FRAME_LSB +: FRAME_W] !== t.frame_number) begin
                    $display("%t: frame_number expected %h actual %h", $realtime,
                             t.frame_number, m_tdata[FRAME_LSB +: FRAME_W]);
                    mismatches++;
                end
                if (m_tdata[PHYS_LSB +: ADDR_W] !== t.physical_addr) begin
                    $display("%t: physical_addr expected %h actual %h", $realtime,
                             t.physical_addr, m_tdata[PHYS_LSB +: ADDR_W]);
                    mismatches++;
                end
                if (m_tdata[FAULT_BIT] !== t.page_fault) begin
                    $display("%t: page_fault expected %b actual %b", $realtime,
                             t.page_fault, m_tdata[FAULT_BIT]);
                    mismatches++;
                end
                if (m_tdata[EVV_BIT] !== t.evicted_valid) begin
                    $display("%t: evicted_valid expected %b actual %b", $realtime,
                             t.evicted_valid, m_tdata[EVV_BIT]);
                    mismatches++;
                end
                if (m_tdata[EVP_LSB +: PAGE_W] !== t.evicted_page) begin
                    $display("%t: evicted_page expected %h actual %h", $realtime,
                             t.evicted_page, m_tdata[EVP_LSB +: PAGE_W]);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        mismatches    = 0;
        stall_on      = 1'b1;
        hold_requests = 0;
        hold_served   = 0;
        recent_wr     = 0;
        frames_used   = 0;
        foreach (page_mapped[i])
            page_mapped[i] = 1'b0;
        foreach (page_to_frame[i])
            page_to_frame[i] = '0;
        foreach (frame_to_page[i])
            frame_to_page[i] = '0;
        foreach (recent_pages[i])
            recent_pages[i] = '0;
        load_victim_seed(SEED_RESET);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_corner_addrs();
        test_seed_writes();
        test_random_traffic(550);
        test_output_stall();
        test_full_rate();
        test_random_traffic(350);
        test_fill_all_frames();
        test_random_traffic(200);
        wait_drained();

        if (mismatches == 0 && pending_xlate.size() == 0)
            $display("** demand_paging_translator: PASSED **");
        else
            $display("** demand_paging_translator: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("** demand_paging_translator: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/dpt_pkg.sv
hdl/dpt_ram.sv
hdl/dpt_ctrl.sv
hdl/dpt_dp.sv
hdl/demand_paging_translator.sv
sim/tb_demand_paging_translator.sv
